// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for clocked assertions with a synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/fbpt_pkg.sv
// ----------------------------------------------------------------------------
// fbpt_pkg
// Types, constants and the microcode table of the base-2 Fermat test.
// ----------------------------------------------------------------------------
package fbpt_pkg;

  localparam int MOD_BITS_DEFAULT = 30;
  localparam int CAND_W           = 31;
  localparam int STEP_W           = 4;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_NONE,
    OP_MUL_SETUP,
    OP_MUL_STEP,
    OP_TAKE_RES,
    OP_SQR_SETUP,
    OP_TAKE_BASE,
    OP_REPORT,
    OP_REPORT_SPEC
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_START,
    COND_SPECIAL,
    COND_E_ZERO,
    COND_E_EVEN,
    COND_B_NZ
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  localparam step_t S_IDLE      = 4'd0;
  localparam step_t S_CHECK     = 4'd1;
  localparam step_t S_LOOP      = 4'd2;
  localparam step_t S_MUL_SETUP = 4'd3;
  localparam step_t S_MUL_STEP  = 4'd4;
  localparam step_t S_TAKE_RES  = 4'd5;
  localparam step_t S_SQR_SETUP = 4'd6;
  localparam step_t S_SQR_STEP  = 4'd7;
  localparam step_t S_TAKE_BASE = 4'd8;
  localparam step_t S_REPORT    = 4'd9;
  localparam step_t S_SPECIAL   = 4'd10;

  function automatic ctrl_t microcode(step_t step);
    ctrl_t word;
    unique case (step)
      S_IDLE:      word = '{OP_IDLE,        COND_NO_START, S_IDLE};
      S_CHECK:     word = '{OP_NONE,        COND_SPECIAL,  S_SPECIAL};
      S_LOOP:      word = '{OP_NONE,        COND_E_ZERO,   S_REPORT};
      S_MUL_SETUP: word = '{OP_MUL_SETUP,   COND_E_EVEN,   S_SQR_SETUP};
      S_MUL_STEP:  word = '{OP_MUL_STEP,    COND_B_NZ,     S_MUL_STEP};
      S_TAKE_RES:  word = '{OP_TAKE_RES,    COND_NEVER,    S_IDLE};
      S_SQR_SETUP: word = '{OP_SQR_SETUP,   COND_NEVER,    S_IDLE};
      S_SQR_STEP:  word = '{OP_MUL_STEP,    COND_B_NZ,     S_SQR_STEP};
      S_TAKE_BASE: word = '{OP_TAKE_BASE,   COND_ALWAYS,   S_LOOP};
      S_REPORT:    word = '{OP_REPORT,      COND_ALWAYS,   S_IDLE};
      S_SPECIAL:   word = '{OP_REPORT_SPEC, COND_ALWAYS,   S_IDLE};
      default:     word = '{OP_NONE,        COND_ALWAYS,   S_IDLE};
    endcase
    return word;
  endfunction

endpackage

// File: hw/rtl/fermat_base2_prime_test.sv
// ----------------------------------------------------------------------------
// fermat_base2_prime_test
// Base-2 Fermat test: reports whether 2^(p-1) mod p equals 1, run by a
// microcoded sequencer over a square-and-multiply datapath.
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  input     start, busy         candidate
//  result    done (one cycle)    probable_prime, too_large
//
//  An item is taken when start is high and busy is low; busy then stays high.
//  Each modular product is a shift-and-add over the multiplier bits, and the
//  sequencer runs one or two of them per exponent bit, with a loop test per
//  bit; a special candidate skips them and goes straight to its report.
//  done rises in the cycle in which busy falls; the receiver cannot stall.
//  Reset returns the sequencer to its idle step and clears done.
module fermat_base2_prime_test #(
  parameter int MOD_BITS = fbpt_pkg::MOD_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [fbpt_pkg::CAND_W-1:0] candidate,
  output logic                        done,
  output logic                        probable_prime,
  output logic                        too_large
);

  localparam int W = (MOD_BITS < fbpt_pkg::CAND_W) ? MOD_BITS : fbpt_pkg::CAND_W;

  fbpt_pkg::step_t pc;
  fbpt_pkg::step_t pc_next;
  fbpt_pkg::ctrl_t ctrl;
  logic            jump;

  logic [W-1:0] p;
  logic [W-1:0] e;
  logic [W-1:0] result;
  logic [W-1:0] base;
  logic [W-1:0] acc;
  logic [W-1:0] addend;
  logic [W-1:0] b;
  logic         big;
  logic         special;
  logic         special_prime;

  logic         big_in;
  logic         small_in;
  logic [W:0]   acc_sum;
  logic [W:0]   dbl_sum;
  logic [W-1:0] acc_red;
  logic [W-1:0] dbl_red;

  assign ctrl = fbpt_pkg::microcode(pc);
  assign busy = (pc != fbpt_pkg::S_IDLE);

  assign big_in   = ((candidate >> W) != '0);
  assign small_in = (candidate < fbpt_pkg::CAND_W'(3));

  assign acc_sum = {1'b0, acc} + {1'b0, addend};
  assign dbl_sum = {addend, 1'b0};
  assign acc_red = (acc_sum >= {1'b0, p}) ? W'(acc_sum - {1'b0, p}) : acc_sum[W-1:0];
  assign dbl_red = (dbl_sum >= {1'b0, p}) ? W'(dbl_sum - {1'b0, p}) : dbl_sum[W-1:0];

  always_comb begin
    unique case (ctrl.cond)
      fbpt_pkg::COND_NEVER:    jump = 1'b0;
      fbpt_pkg::COND_ALWAYS:   jump = 1'b1;
      fbpt_pkg::COND_NO_START: jump = !start;
      fbpt_pkg::COND_SPECIAL:  jump = special;
      fbpt_pkg::COND_E_ZERO:   jump = (e == '0);
      fbpt_pkg::COND_E_EVEN:   jump = !e[0];
      fbpt_pkg::COND_B_NZ:     jump = (b != '0);
      default:                 jump = 1'b1;
    endcase
    pc_next = jump ? ctrl.target : fbpt_pkg::step_t'(pc + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= fbpt_pkg::S_IDLE;
      done <= 1'b0;
    end else begin
      pc   <= pc_next;
      done <= (ctrl.op == fbpt_pkg::OP_REPORT) || (ctrl.op == fbpt_pkg::OP_REPORT_SPEC);
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      fbpt_pkg::OP_IDLE: begin
        if (start) begin
          p             <= candidate[W-1:0];
          e             <= candidate[W-1:0] - 1'b1;
          result        <= W'(1);
          base          <= W'(2);
          big           <= big_in;
          special       <= big_in || small_in;
          special_prime <= !big_in && (candidate < fbpt_pkg::CAND_W'(2));
        end
      end
      fbpt_pkg::OP_MUL_SETUP: begin
        acc    <= '0;
        addend <= result;
        b      <= base;
      end
      fbpt_pkg::OP_MUL_STEP: begin
        if (b[0]) begin
          acc <= acc_red;
        end
        addend <= dbl_red;
        b      <= b >> 1;
      end
      fbpt_pkg::OP_TAKE_RES: begin
        result <= acc;
      end
      fbpt_pkg::OP_SQR_SETUP: begin
        acc    <= '0;
        addend <= base;
        b      <= base;
      end
      fbpt_pkg::OP_TAKE_BASE: begin
        base <= acc;
        e    <= e >> 1;
      end
      fbpt_pkg::OP_REPORT: begin
        probable_prime <= (result == W'(1));
        too_large      <= 1'b0;
      end
      fbpt_pkg::OP_REPORT_SPEC: begin
        probable_prime <= special_prime;
        too_large      <= big;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hw/rtl/fbpt_checker.sv
// ----------------------------------------------------------------------------
// fbpt_checker
// Port-level checks on the Fermat test block, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fbpt_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic probable_prime,
  input logic too_large
);

  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `ASSERT_IMPL(a_done_idle, clk, rst, done, !busy)
  `ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `ASSERT_IMPL(a_busy_fall_done, clk, rst, $fell(busy), done)
  `ASSERT_IMPL(a_large_not_prime, clk, rst, done && too_large, !probable_prime)

endmodule

bind fermat_base2_prime_test fbpt_checker u_fbpt_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .probable_prime (probable_prime),
  .too_large      (too_large)
);

// File: tb/fermat_base2_prime_test_checker.sv
// ----------------------------------------------------------------------------
// fermat_base2_prime_test_checker
// Watches the command and result channels of the base-2 Fermat test, predicts
// the verdict for every accepted candidate and compares it with each result.
// ----------------------------------------------------------------------------
module fermat_base2_prime_test_checker #(
  parameter int MOD_BITS = fbpt_pkg::MOD_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [fbpt_pkg::CAND_W-1:0] candidate,
  input  logic                        done,
  input  logic                        probable_prime,
  input  logic                        too_large,
  output int                          failures,
  output int                          pending
);

  typedef struct packed {
    logic probable_prime;
    logic too_large;
  } verdict_t;

  verdict_t verdicts_due[$];

  function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b,
                                              longint unsigned m);
    longint unsigned acc;
    longint unsigned addend;
    longint unsigned multiplier;
    acc = 0;
    addend = a;
    multiplier = b;
    while (multiplier != 0) begin
      if ((multiplier & 1) != 0) begin
        acc = acc + addend;
        if (acc >= m) acc = acc - m;
      end
      addend = addend + addend;
      if (addend >= m) addend = addend - m;
      multiplier = multiplier >> 1;
    end
    return acc;
  endfunction

  function automatic verdict_t fermat_verdict(logic [fbpt_pkg::CAND_W-1:0] cand);
    longint unsigned p;
    longint unsigned power;
    longint unsigned square;
    longint unsigned exponent;
    verdict_t v;
    p = cand;
    v = '0;
    if (MOD_BITS < fbpt_pkg::CAND_W && p >= (64'd1 << MOD_BITS)) begin
      v.too_large = 1'b1;
    end else if (p < 2) begin
      v.probable_prime = 1'b1;
    end else if (p > 2) begin
      power = 1;
      square = 2;
      exponent = p - 1;
      while (exponent != 0) begin
        if ((exponent & 1) != 0) power = mul_mod(power, square, p);
        square = mul_mod(square, square, p);
        exponent = exponent >> 1;
      end
      v.probable_prime = (power == 1);
    end
    return v;
  endfunction

  initial begin
    failures = 0;
    pending = 0;
  end

  always @(posedge clk) begin : watch
    verdict_t want;
    int errs;
    errs = 0;
    if (!rst) begin
      if (done) begin
        if (verdicts_due.size() == 0) begin
          $error("result with no item outstanding: probable_prime %0b, too_large %0b",
                 probable_prime, too_large);
          errs++;
        end else begin
          want = verdicts_due.pop_front();
          if (probable_prime !== want.probable_prime) begin
            $error("probable_prime: expected %0b, actual %0b",
                   want.probable_prime, probable_prime);
            errs++;
          end
          if (too_large !== want.too_large) begin
            $error("too_large: expected %0b, actual %0b", want.too_large, too_large);
            errs++;
          end
        end
      end
      if (start && !busy) verdicts_due.push_back(fermat_verdict(candidate));
      failures <= failures + errs;
      pending <= verdicts_due.size();
    end
  end

endmodule

// File: tb/tb_fermat_base2_prime_test.sv
// ----------------------------------------------------------------------------
// tb_fermat_base2_prime_test
// Drives candidates into the base-2 Fermat test, directed corner values first
// and then random ones, with random and burst spacing, and gives the verdict.
// ----------------------------------------------------------------------------
module tb_fermat_base2_prime_test;

  localparam int MOD_BITS     = fbpt_pkg::MOD_BITS_DEFAULT;
  localparam int RANDOM_ITEMS = 280;
  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [fbpt_pkg::CAND_W-1:0] BOUND = fbpt_pkg::CAND_W'(1) << MOD_BITS;

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        busy;
  logic [fbpt_pkg::CAND_W-1:0] candidate;
  logic                        done;
  logic                        probable_prime;
  logic                        too_large;
  int                          failures;
  int                          pending;
  int                          idle_cycles;

  logic [fbpt_pkg::CAND_W-1:0] candidates[$];

  fermat_base2_prime_test #(
    .MOD_BITS(MOD_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .candidate(candidate),
    .done(done),
    .probable_prime(probable_prime),
    .too_large(too_large)
  );

  fermat_base2_prime_test_checker #(
    .MOD_BITS(MOD_BITS)
  ) verdict_monitor (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .candidate(candidate),
    .done(done),
    .probable_prime(probable_prime),
    .too_large(too_large),
    .failures(failures),
    .pending(pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Most candidates are narrow so that the long exponentiations stay rare.
  function automatic logic [fbpt_pkg::CAND_W-1:0] random_candidate();
    int unsigned pick;
    int unsigned width;
    logic [fbpt_pkg::CAND_W-1:0] value;
    pick = $urandom_range(0, 99);
    value = fbpt_pkg::CAND_W'($urandom);
    if (pick < 8) begin
      value = value | BOUND;
    end else if (pick < 18) begin
      value = value & (BOUND - fbpt_pkg::CAND_W'(1));
    end else begin
      width = $urandom_range(2, 14);
      value = value & ((fbpt_pkg::CAND_W'(1) << width) - fbpt_pkg::CAND_W'(1));
      value[width-1] = 1'b1;
      if (pick < 60) value[0] = 1'b1;
    end
    return value;
  endfunction

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[fermat_base2_prime_test] ERROR");
      $finish;
    end
  end

  initial begin
    int  gap;
    int  directed_count;
    bit  burst;
    bit  hold;
    rst = 1'b1;
    start = 1'b0;
    candidate = '0;
    idle_cycles = 0;
    burst = 1'b0;

    candidates = '{31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd9, 31'd127,
                   31'd341, 31'd561, 31'd1105, 31'd2047, 31'd65537,
                   31'h3FFFFFFF, 31'd1073741789, 31'h2AAAAAAA, 31'h15555555,
                   31'h40000000, 31'h7FFFFFFF, 31'h55555555};
    directed_count = candidates.size();
    repeat (RANDOM_ITEMS) candidates.push_back(random_candidate());

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < candidates.size(); i++) begin
      if (i % 40 == 0) burst = ($urandom_range(0, 2) == 0);
      gap = burst ? 0 : $urandom_range(0, 8);
      hold = (i == directed_count) || (i == candidates.size() / 2);
      if (hold || gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
        if (hold) begin
          do @(posedge clk); while (pending != 0);
        end
      end
      start <= 1'b1;
      candidate <= candidates[i];
      do @(posedge clk); while (busy);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("[fermat_base2_prime_test] OK");
    end else begin
      $display("[fermat_base2_prime_test] ERROR");
    end
    $finish;
  end

endmodule
